// ===== hdl/hre_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hre_pkg
// Shared widths, types and helpers of the horizontal Rosenfeld edge block.
// ---------------------------------------------------------------------------
package hre_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int RADIUS_W    = 6;
    localparam int MAX_RADIUS  = 32;
    localparam int STORE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int OFF_W       = SLOT_W + 1;
    localparam int SEEN_W      = 7;
    localparam int PEND_W      = 6;
    localparam int K_W         = $clog2(MAX_RADIUS);
    localparam int DIVD_W      = 13;
    localparam int SUM_W       = DIVD_W + 1;
    localparam int DIV_STEPS   = DIVD_W;
    localparam int DSTEP_W     = $clog2(DIV_STEPS);
    localparam int EMIT_W      = $clog2(MAX_RADIUS) + 1;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = '0;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = RADIUS_W'(1);

    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic issue_right;
        logic issue_left;
        logic div_load;
        logic div_step;
        logic emit;
        logic row_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic pend_zero;
        logic pend_ge_r;
        logic last;
        logic k_last;
        logic div_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [RADIUS_W-1:0] eff_radius(input logic [RADIUS_W-1:0] r);
        logic [RADIUS_W-1:0] res;
        res = r;
        if (r == '0)
        begin
            res = RADIUS_W'(1);
        end
        else if (r > RADIUS_W'(MAX_RADIUS))
        begin
            res = RADIUS_W'(MAX_RADIUS);
        end
        return res;
    endfunction

endpackage : hre_pkg
`default_nettype wire

// ===== hdl/hre_intf.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hre_pixel_if / hre_result_if
// Valid/ready channels for incoming pixels and filtered results.
// ---------------------------------------------------------------------------
interface hre_pixel_if import hre_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    logic  row_end;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output row_end, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input row_end, output ready);
endinterface : hre_pixel_if

interface hre_result_if import hre_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic  row_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output row_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input row_last, output ready);
endinterface : hre_result_if
`default_nettype wire

// ===== hdl/hre_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hre_ctrl
// Sequencer: takes one pixel, then walks the windows and the divider for
// every result that pixel releases.
// ---------------------------------------------------------------------------
module hre_ctrl import hre_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RIGHT,
        S_LEFT,
        S_DRAIN,
        S_DIVLD,
        S_DIV,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic                ready_reg, ready_next;
    logic [EMIT_W-1:0]   emitted_reg, emitted_next;
    logic                more;

    assign in_ready = ready_reg;
    assign more = !status.pend_zero && (emitted_reg < EMIT_W'(MAX_RADIUS))
                  && (status.last || status.pend_ge_r);

    always_comb
    begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        emitted_next = emitted_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ready_reg && in_valid)
                begin
                    cmd.accept   = 1'b1;
                    ready_next   = 1'b0;
                    emitted_next = '0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (more)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_RIGHT;
                end
                else
                begin
                    cmd.row_clear = status.last;
                    ready_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RIGHT:
            begin
                cmd.issue_right = 1'b1;
                if (status.k_last)
                begin
                    state_next = S_LEFT;
                end
            end
            S_LEFT:
            begin
                cmd.issue_left = 1'b1;
                if (status.k_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIVLD;
            end
            S_DIVLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    emitted_next = emitted_reg + EMIT_W'(1);
                    state_next   = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ready_reg   <= 1'b1;
            emitted_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ready_reg   <= ready_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule : hre_ctrl
`default_nettype wire

// ===== hdl/hre_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hre_datapath
// Row store, window accumulators, shift-subtract divider and result register.
// ---------------------------------------------------------------------------
module hre_datapath import hre_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               status,
    input  wire logic [RADIUS_W-1:0] radius,
    input  wire pixel_t              pix_in,
    input  wire logic                row_end_in,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output pixel_t                   out_pix,
    output logic                     out_row_last
);

    pixel_t                     store [STORE_DEPTH];
    logic [SLOT_W-1:0]          head_reg;
    logic [SEEN_W-1:0]          seen_reg;
    logic [PEND_W-1:0]          pend_reg;
    logic                       last_reg;
    logic [K_W-1:0]             k_reg;
    logic [DSTEP_W-1:0]         dstep_reg;
    pixel_t                     rd_reg;
    logic                       rd_en_reg;
    logic                       rd_sub_reg;
    logic signed [SUM_W-1:0]    sum_reg [NUM_CHAN];
    logic [DIVD_W-1:0]          quo_reg [NUM_CHAN];
    logic [RADIUS_W-1:0]        rem_reg [NUM_CHAN];
    logic                       out_valid_reg;
    pixel_t                     out_pix_reg;
    logic                       out_last_reg;

    logic [PEND_W-1:0]          back_off;
    logic [OFF_W-1:0]           right_off;
    logic [OFF_W-1:0]           left_off;
    logic                       right_en;
    logic                       left_en;
    logic [OFF_W-1:0]           off_sel;
    logic [SLOT_W-1:0]          rd_addr;
    logic [SLOT_W-1:0]          wr_addr;
    logic                       issue;
    logic                       out_free;

    assign back_off  = pend_reg - PEND_W'(1);
    assign right_off = OFF_W'(back_off) - OFF_W'(k_reg);
    assign left_off  = OFF_W'(back_off) + OFF_W'(1) + OFF_W'(k_reg);
    assign right_en  = !right_off[OFF_W-1];
    assign left_en   = (left_off < OFF_W'(seen_reg)) && !left_off[OFF_W-1];
    assign off_sel   = cmd.issue_left ? left_off : right_off;
    assign rd_addr   = head_reg - off_sel[SLOT_W-1:0];
    assign wr_addr   = head_reg + SLOT_W'(1);
    assign issue     = cmd.issue_right || cmd.issue_left;
    assign out_free  = !out_valid_reg || out_ready;

    assign status.pend_zero = (pend_reg == '0);
    assign status.pend_ge_r = (pend_reg >= PEND_W'(radius));
    assign status.last      = last_reg;
    assign status.k_last    = (RADIUS_W'(k_reg) == radius - RADIUS_W'(1));
    assign status.div_last  = (dstep_reg == DSTEP_W'(DIV_STEPS - 1));
    assign status.out_free  = out_free;

    assign out_valid    = out_valid_reg;
    assign out_pix      = out_pix_reg;
    assign out_row_last = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            store[wr_addr] <= pix_in;
        end
        rd_reg <= store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            seen_reg      <= '0;
            pend_reg      <= '0;
            last_reg      <= 1'b0;
            k_reg         <= '0;
            dstep_reg     <= '0;
            rd_en_reg     <= 1'b0;
            rd_sub_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                head_reg <= wr_addr;
                last_reg <= row_end_in;
                if (seen_reg != '1)
                begin
                    seen_reg <= seen_reg + SEEN_W'(1);
                end
                if (pend_reg != '1)
                begin
                    pend_reg <= pend_reg + PEND_W'(1);
                end
            end
            else if (cmd.emit)
            begin
                pend_reg <= pend_reg - PEND_W'(1);
            end
            else if (cmd.row_clear)
            begin
                pend_reg <= '0;
                seen_reg <= '0;
            end

            if (cmd.start || (issue && status.k_last))
            begin
                k_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + K_W'(1);
            end

            if (cmd.div_load)
            begin
                dstep_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dstep_reg <= dstep_reg + DSTEP_W'(1);
            end

            rd_en_reg  <= issue && (cmd.issue_left ? left_en : right_en);
            rd_sub_reg <= cmd.issue_left;

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (cmd.start)
            begin
                sum_reg[c] <= '0;
            end
            else if (rd_en_reg)
            begin
                if (rd_sub_reg)
                begin
                    sum_reg[c] <= sum_reg[c] - $signed(SUM_W'(rd_reg[c]));
                end
                else
                begin
                    sum_reg[c] <= sum_reg[c] + $signed(SUM_W'(rd_reg[c]));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (cmd.div_load)
            begin
                quo_reg[c] <= sum_reg[c][SUM_W-1] ? '0 : sum_reg[c][DIVD_W-1:0];
                rem_reg[c] <= '0;
            end
            else if (cmd.div_step)
            begin
                if ({rem_reg[c], quo_reg[c][DIVD_W-1]} >= (RADIUS_W+1)'(radius))
                begin
                    rem_reg[c] <= RADIUS_W'({rem_reg[c], quo_reg[c][DIVD_W-1]}
                                            - (RADIUS_W+1)'(radius));
                    quo_reg[c] <= {quo_reg[c][DIVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= RADIUS_W'({rem_reg[c], quo_reg[c][DIVD_W-1]});
                    quo_reg[c] <= {quo_reg[c][DIVD_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                out_pix_reg[c] <= (|quo_reg[c][DIVD_W-1:CHAN_W]) ? '1
                                                                  : quo_reg[c][CHAN_W-1:0];
            end
            out_last_reg <= last_reg && (pend_reg == PEND_W'(1));
        end
    end

endmodule : hre_datapath
`default_nettype wire

// ===== hdl/horizontal_rosenfeld_edge.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// horizontal_rosenfeld_edge
// Horizontal Rosenfeld edge operator over a row-ordered RGB pixel stream.
// ---------------------------------------------------------------------------
// One pixel is taken at a time. For each result it releases, the block gathers
// the window sums one pixel per cycle through the single read port of the
// 64-entry row store, divides by R (the effective radius) with a 13-step
// shift-subtract divider, one per channel, all three running together, and
// then waits for the result register to drain. In a row, a pixel normally
// releases one result; the last pixel releases all outstanding results of the
// row. The row store needs no clearing after reset. Radius is register 0 (byte
// address 0); write it only while the block is idle.
// ---------------------------------------------------------------------------
module horizontal_rosenfeld_edge import hre_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    hre_pixel_if.sink               pixels,
    hre_result_if.source            results,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [RADIUS_W-1:0] radius_reg;
    logic [RADIUS_W-1:0] radius_eff;
    logic                reg_sel;
    dp_cmd_t             cmd;
    dp_status_t          status;
    pixel_t              pix_in;
    pixel_t              out_pix;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_RADIUS);
    assign prdata  = reg_sel ? PDATA_W'(radius_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    assign radius_eff = eff_radius(radius_reg);

    assign pix_in[CH_RED]   = pixels.red_in;
    assign pix_in[CH_GREEN] = pixels.green_in;
    assign pix_in[CH_BLUE]  = pixels.blue_in;

    assign results.red_out   = out_pix[CH_RED];
    assign results.green_out = out_pix[CH_GREEN];
    assign results.blue_out  = out_pix[CH_BLUE];

    hre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .status   (status),
        .cmd      (cmd)
    );

    hre_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .radius       (radius_eff),
        .pix_in       (pix_in),
        .row_end_in   (pixels.row_end),
        .out_ready    (results.ready),
        .out_valid    (results.valid),
        .out_pix      (out_pix),
        .out_row_last (results.row_last)
    );

    a_one_pixel_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.ready |=> !pixels.ready)
        else $error("pixel taken while previous one still in work");

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_row_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && results.row_last |=> !results.valid)
        else $error("result follows the last result of a row");

endmodule : horizontal_rosenfeld_edge
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the horizontal Rosenfeld edge block. A queue-fed
// driver offers pixel rows and a monitor predicts every filtered result per
// accepted pixel, then checks each result transfer in order. Phases vary the
// radius through its extremes and alternate sender idling, receiver stalls
// and a long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;
    import hre_pkg::*;

    localparam int LIMIT    = 1500000;
    localparam int SETTLE   = 2 * MAX_RADIUS + 40;
    localparam int HOLD_LEN = 600;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  row_end;
    } pixel_item_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  row_last;
    } edge_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    wire  [PDATA_W-1:0] prdata;
    wire                pready;

    hre_pixel_if  pix_if ();
    hre_result_if res_if ();

    horizontal_rosenfeld_edge u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_if),
        .results (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pixel_item_t pixel_feed[$];
    edge_t       pending_edges[$];
    pixel_item_t drv_item;

    int send_idle;
    int stall_pct;
    bit hold_phase;
    int hold_count = 0;
    int cycle_count = 0;
    int mismatches = 0;

    pixel_t              row_store [STORE_DEPTH];
    logic [SLOT_W-1:0]   row_head = '0;
    logic [SEEN_W-1:0]   row_seen = '0;
    logic [PEND_W-1:0]   row_pending = '0;
    logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int radius_limit(input logic [RADIUS_W-1:0] v);
        int r;
        r = int'(v);
        if (r < 1)
        begin
            r = 1;
        end
        if (r > MAX_RADIUS)
        begin
            r = MAX_RADIUS;
        end
        return r;
    endfunction

    function automatic edge_t edge_at(input int d, input int r);
        int                rsum [NUM_CHAN];
        int                lsum [NUM_CHAN];
        int                off;
        int                q;
        logic [SLOT_W-1:0] slot;
        pixel_t            p;
        pixel_t            outp;
        edge_t             e;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            rsum[c] = 0;
            lsum[c] = 0;
        end
        for (int k = 0; k < r; k++)
        begin
            if (d >= k)
            begin
                slot = row_head - SLOT_W'(d - k);
                p = row_store[slot];
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    rsum[c] += p[c];
                end
            end
            off = d + 1 + k;
            if (off < int'(row_seen) && off < STORE_DEPTH)
            begin
                slot = row_head - SLOT_W'(off);
                p = row_store[slot];
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    lsum[c] += p[c];
                end
            end
        end
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            q = (rsum[c] > lsum[c]) ? (rsum[c] - lsum[c]) / r : 0;
            if (q > 255)
            begin
                q = 255;
            end
            outp[c] = chan_t'(q);
        end
        e.red      = outp[CH_RED];
        e.green    = outp[CH_GREEN];
        e.blue     = outp[CH_BLUE];
        e.row_last = 1'b0;
        return e;
    endfunction

    function automatic void absorb_pixel(input pixel_item_t it);
        int    r;
        int    n;
        edge_t e;
        r = radius_limit(radius_reg);
        n = 0;
        row_head = row_head + SLOT_W'(1);
        row_store[row_head][CH_RED]   = it.red;
        row_store[row_head][CH_GREEN] = it.green;
        row_store[row_head][CH_BLUE]  = it.blue;
        if (row_seen != {SEEN_W{1'b1}})
        begin
            row_seen = row_seen + SEEN_W'(1);
        end
        if (row_pending != {PEND_W{1'b1}})
        begin
            row_pending = row_pending + PEND_W'(1);
        end
        while (row_pending != 0 && n < MAX_RADIUS &&
               (it.row_end || int'(row_pending) >= r))
        begin
            e = edge_at(int'(row_pending) - 1, r);
            row_pending = row_pending - PEND_W'(1);
            e.row_last = it.row_end && (row_pending == 0);
            pending_edges.push_back(e);
            n++;
        end
        if (it.row_end)
        begin
            row_pending = '0;
            row_seen = '0;
        end
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // monitor: predict on pixel transfers, check on result transfers
    always @(posedge clk)
    begin
        edge_t       want;
        pixel_item_t seen_px;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == {REG_RADIUS, 2'b00})
            begin
                radius_reg = pwdata[RADIUS_W-1:0];
            end
            if (pix_if.valid && pix_if.ready)
            begin
                seen_px.red     = pix_if.red_in;
                seen_px.green   = pix_if.green_in;
                seen_px.blue    = pix_if.blue_in;
                seen_px.row_end = pix_if.row_end;
                absorb_pixel(seen_px);
            end
            if (res_if.valid && res_if.ready)
            begin
                if (pending_edges.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0b",
                             $time, res_if.red_out, res_if.green_out, res_if.blue_out,
                             res_if.row_last);
                    mismatches++;
                end
                else
                begin
                    want = pending_edges.pop_front();
                    check_field("red_out", want.red, res_if.red_out);
                    check_field("green_out", want.green, res_if.green_out);
                    check_field("blue_out", want.blue, res_if.blue_out);
                    check_field("row_last", want.row_last, res_if.row_last);
                end
            end
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_if.valid <= 1'b0;
        end
        else if (!pix_if.valid || pix_if.ready)
        begin
            if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                drv_item = pixel_feed.pop_front();
                pix_if.valid    <= 1'b1;
                pix_if.red_in   <= drv_item.red;
                pix_if.green_in <= drv_item.green;
                pix_if.blue_in  <= drv_item.blue;
                pix_if.row_end  <= drv_item.row_end;
            end
            else
            begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // receiver, with a one-off long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else if (hold_phase && hold_count < HOLD_LEN)
        begin
            hold_count   <= hold_count + 1;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_px(input int r, input int g, input int b, input bit e);
        pixel_item_t it;
        it.red     = chan_t'(r);
        it.green   = chan_t'(g);
        it.blue    = chan_t'(b);
        it.row_end = e;
        pixel_feed.push_back(it);
    endtask

    function automatic int chan_pick();
        int v;
        case ($urandom_range(3))
            0: v = 0;
            1: v = 255;
            default: v = $urandom_range(255);
        endcase
        return v;
    endfunction

    task automatic queue_row(input int len, input bit close);
        int r;
        int g;
        int b;
        r = chan_pick();
        g = chan_pick();
        b = chan_pick();
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(2) != 0)
            begin
                r = chan_pick();
                g = chan_pick();
                b = chan_pick();
            end
            push_px(r, g, b, close && (i == len - 1));
        end
    endtask

    task automatic radius_write(input int v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_RADIUS, 2'b00};
        pwdata  <= PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (pixel_feed.size() != 0 || pix_if.valid || pending_edges.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        @(posedge clk);
        case (mode)
            0:
            begin
                send_idle <= 0;
                stall_pct <= 0;
            end
            1:
            begin
                send_idle <= 48;
                stall_pct <= 0;
            end
            2:
            begin
                send_idle <= 0;
                stall_pct <= 48;
            end
            default:
            begin
                send_idle <= 8;
                stall_pct <= 8;
            end
        endcase
    endtask

    initial
    begin
        int rv;
        int r_eff;
        int count;
        int len;
        rst_n           = 1'b0;
        pix_if.valid    = 1'b0;
        pix_if.red_in   = '0;
        pix_if.green_in = '0;
        pix_if.blue_in  = '0;
        pix_if.row_end  = 1'b0;
        res_if.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        send_idle       = 0;
        stall_pct       = 0;
        hold_phase      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radius, single-pixel row and hard steps
        push_px(255, 255, 255, 1'b1);
        push_px(0, 0, 0, 1'b0);
        push_px(255, 0, 128, 1'b0);
        push_px(0, 255, 128, 1'b0);
        push_px(255, 255, 255, 1'b1);
        drain();
        radius_write(2);
        push_px(10, 200, 0, 1'b0);
        push_px(250, 0, 255, 1'b0);
        push_px(250, 0, 255, 1'b0);
        push_px(0, 255, 0, 1'b0);
        push_px(128, 128, 128, 1'b1);
        drain();
        radius_write(MAX_RADIUS);
        push_px(255, 255, 255, 1'b0);
        push_px(255, 255, 255, 1'b0);
        push_px(255, 255, 255, 1'b0);
        push_px(0, 0, 0, 1'b1);
        drain();
        radius_write(0);
        push_px(0, 0, 0, 1'b0);
        push_px(255, 255, 255, 1'b0);
        push_px(1, 2, 3, 1'b1);
        drain();
        radius_write(63);
        push_px(200, 100, 50, 1'b0);
        push_px(255, 255, 255, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: rv = 1;
                1: rv = MAX_RADIUS;
                2: rv = 0;
                3: rv = $urandom_range(63, MAX_RADIUS + 1);
                4: rv = $urandom_range(2, 6);
                default: rv = $urandom_range(1, MAX_RADIUS);
            endcase
            r_eff = radius_limit(RADIUS_W'(rv));
            radius_write(rv);
            set_idling(ph % 4);
            if (ph == 4)
            begin
                hold_phase <= 1'b1;
            end
            count = 0;
            while (count < 32)
            begin
                len = $urandom_range(1, 2 * r_eff + 4);
                if (count + len > 40)
                begin
                    len = 40 - count;
                end
                count += len;
                queue_row(len, (ph == 5 && count >= 32) ? 1'b0 : 1'b1);
            end
            drain();
            hold_phase <= 1'b0;
        end

        // long row: store wrap and saturated pixel count
        radius_write(3);
        set_idling(3);
        queue_row(140, 1'b1);
        drain();

        if (mismatches == 0 && pending_edges.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule : testbench
`default_nettype wire
